// ----- hdl/bdq_pkg.sv -----
// Shared action codes, status codes and sequencer state type for the bounded deque.
package bdq_pkg;

	localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
	localparam logic [2:0] ACT_POP_BACK   = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_PUSH_FRONT = 3'd3;
	localparam logic [2:0] ACT_ERASE      = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam int PortWidth = 32;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_RD       = 7'b0000010,
		S_SCAN_RD  = 7'b0000100,
		S_SCAN_CMP = 7'b0001000,
		S_SHIFT_RD = 7'b0010000,
		S_SHIFT_WR = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

endpackage

// ----- hdl/bdq_ring.sv -----
// Ring address unit: maps an offset from the front entry to a store position.
module bdq_ring #(
	parameter int DEPTH = 16
) (
	input  logic [$clog2(DEPTH)-1:0] base,
	input  logic [$clog2(DEPTH)-1:0] offset,
	output logic [$clog2(DEPTH)-1:0] slot
);
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW:0] DepthW = (AW+1)'(DEPTH);

	logic [AW:0] sum;

	always_comb begin
		sum = {1'b0, base} + {1'b0, offset};
		if (sum >= DepthW) begin
			slot = AW'(sum - DepthW);
		end else begin
			slot = AW'(sum);
		end
	end

endmodule

// ----- hdl/bounded_deque_with_erase.sv -----
// Bounded double-ended queue with erase of the first matching entry.
// A push, a spare action or a request refused at once goes straight to the result state;
// a pop that removes an entry first reads it in S_RD. An erase reads and compares entries
// from the front to the first match, if any, then moves each later entry one place forward.
// One request at a time: the next request is accepted once the result has been taken.
// Reset empties the queue (count and front index clear); store contents are not cleared.
module bounded_deque_with_erase #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [2:0]                              action,
	input  logic signed [bdq_pkg::PortWidth-1:0]    item_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [bdq_pkg::PortWidth-1:0]    removed_value,
	output logic [1:0]                              status,
	output logic [$clog2(DEPTH+1)-1:0]              entry_total
);
	import bdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FullW = CW'(DEPTH);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

	state_t                state_q;
	logic [2:0]            action_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [1:0]            status_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         front_q;
	logic [AW-1:0]         k_q;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [DATA_WIDTH-1:0] in_data;
	logic [AW-1:0]         k_sel;
	logic [AW-1:0]         slot;
	logic [AW-1:0]         front_dec;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  rd_en;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [CW:0]           k_next;
	logic [CW:0]           k_next2;

	generate
		if (DATA_WIDTH <= PortWidth) begin : g_narrow
			assign in_data = item_value[DATA_WIDTH-1:0];
		end else begin : g_wide
			assign in_data = DATA_WIDTH'({1'b0, item_value});
		end
		if (DATA_WIDTH >= PortWidth) begin : g_out_trunc
			assign removed_value = rem_q[PortWidth-1:0];
		end else begin : g_out_ext
			assign removed_value = {{(PortWidth-DATA_WIDTH){rem_q[DATA_WIDTH-1]}}, rem_q};
		end
	endgenerate

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign status    = status_q;
	assign entry_total = count_q;
	assign full      = (count_q == FullW);
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? LastIdx : front_q - 1'b1;
	assign k_next    = (CW+1)'(k_q) + 1'b1;
	assign k_next2   = (CW+1)'(k_q) + 2'd2;

	always_comb begin
		k_sel = '0;
		case (state_q)
			S_IDLE: begin
				if (action == ACT_PUSH_BACK) begin
					k_sel = AW'(count_q);
				end else if (action == ACT_POP_BACK) begin
					k_sel = AW'(count_q - 1'b1);
				end
			end
			S_RD:       k_sel = AW'(1);
			S_SCAN_RD:  k_sel = k_q;
			S_SHIFT_RD: k_sel = k_q + 1'b1;
			S_SHIFT_WR: k_sel = k_q;
			default:    k_sel = '0;
		endcase
	end

	bdq_ring #(.DEPTH(DEPTH)) u_ring (
		.base   (front_q),
		.offset (k_sel),
		.slot   (slot)
	);

	always_comb begin
		rd_en   = (state_q == S_IDLE) || (state_q == S_SCAN_RD) || (state_q == S_SHIFT_RD);
		wr_en   = 1'b0;
		wr_addr = slot;
		wr_data = rdata_q;
		if (state_q == S_IDLE && accept && !full) begin
			if (action == ACT_PUSH_BACK) begin
				wr_en   = 1'b1;
				wr_data = in_data;
			end else if (action == ACT_PUSH_FRONT) begin
				wr_en   = 1'b1;
				wr_addr = front_dec;
				wr_data = in_data;
			end
		end else if (state_q == S_SHIFT_WR) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			front_q <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_PUSH_BACK: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= S_DONE;
							end
							ACT_PUSH_FRONT: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
									front_q <= front_dec;
								end
								state_q <= S_DONE;
							end
							ACT_POP_BACK, ACT_POP_FRONT: begin
								if (!empty) begin
									count_q <= count_q - 1'b1;
									state_q <= S_RD;
								end else begin
									state_q <= S_DONE;
								end
							end
							ACT_ERASE: begin
								if (!empty) begin
									k_q     <= '0;
									state_q <= S_SCAN_RD;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD: begin
					if (action_q == ACT_POP_FRONT) begin
						front_q <= slot;
					end
					state_q <= S_DONE;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (rdata_q == val_q) begin
						if (k_next < (CW+1)'(count_q)) begin
							state_q <= S_SHIFT_RD;
						end else begin
							count_q <= count_q - 1'b1;
							state_q <= S_DONE;
						end
					end else if (k_next >= (CW+1)'(count_q)) begin
						state_q <= S_DONE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					k_q <= k_q + 1'b1;
					if (k_next2 < (CW+1)'(count_q)) begin
						state_q <= S_SHIFT_RD;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			val_q    <= in_data;
			rem_q    <= '0;
			case (action)
				ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
					status_q <= full ? ST_FULL : ST_OK;
				end
				ACT_POP_BACK, ACT_POP_FRONT, ACT_ERASE: begin
					status_q <= empty ? ST_EMPTY : ST_OK;
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end else if (state_q == S_RD) begin
			rem_q <= rdata_q;
		end else if (state_q == S_SCAN_CMP) begin
			if (rdata_q != val_q && k_next >= (CW+1)'(count_q)) begin
				status_q <= ST_NOT_FOUND;
			end
		end
	end

endmodule

// ----- tb/sv/bounded_deque_with_erase_tb.sv -----
// Self-checking testbench for the bounded deque: directed table, then weighted random requests.
module bounded_deque_with_erase_tb;
	import bdq_pkg::*;

	localparam int DEPTH = 16;
	localparam int DATA_WIDTH = 32;
	localparam int RANDOM_ITEMS = 720;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;

	localparam logic [2:0] ACT_SPARE_5 = 3'd5;
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [31:0] removed;
		logic [1:0]  status;
		logic [4:0]  total;
	} deque_result_t;

	typedef struct {
		logic [2:0]    act;
		logic [31:0]   val;
		int unsigned   reps;
		bit            typed;
		deque_result_t exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] action = ACT_PUSH_BACK;
	logic signed [31:0] item_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] removed_value;
	logic [1:0] status;
	logic [4:0] entry_total;

	logic [31:0] ring_store [DEPTH];
	logic [3:0] ring_front = '0;
	logic [4:0] ring_count = '0;

	deque_result_t pending_results [$];
	stim_row_t directed_rows [$];
	bit req_typed = 1'b0;
	deque_result_t req_expect = '0;
	int mismatch_count = 0;
	int burst_left = 0;

	logic [15:0] ready_pattern = '0;
	int ready_phase = 0;

	bounded_deque_with_erase #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.removed_value(removed_value),
		.status(status),
		.entry_total(entry_total)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("bounded_deque_with_erase: mismatch");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t %s: got %h expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic apply_deque_op(input logic [2:0] act, input logic [31:0] val,
			output deque_result_t res);
		int k;
		int hit;
		logic [3:0] pos;
		res = '0;
		res.status = ST_OK;
		case (act)
			ACT_PUSH_BACK: begin
				if (ring_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					pos = ring_front + ring_count[3:0];
					ring_store[pos] = val;
					ring_count++;
				end
			end
			ACT_PUSH_FRONT: begin
				if (ring_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					ring_front = ring_front - 4'd1;
					ring_store[ring_front] = val;
					ring_count++;
				end
			end
			ACT_POP_BACK: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					ring_count--;
					pos = ring_front + ring_count[3:0];
					res.removed = ring_store[pos];
				end
			end
			ACT_POP_FRONT: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.removed = ring_store[ring_front];
					ring_front = ring_front + 4'd1;
					ring_count--;
				end
			end
			ACT_ERASE: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					hit = -1;
					for (k = 0; k < ring_count; k++) begin
						pos = ring_front + 4'(k);
						if (hit < 0 && ring_store[pos] == val)
							hit = k;
					end
					if (hit < 0) begin
						res.status = ST_NOT_FOUND;
					end else begin
						for (k = hit; k + 1 < ring_count; k++) begin
							pos = ring_front + 4'(k);
							ring_store[pos] = ring_store[4'(ring_front + 4'(k + 1))];
						end
						ring_count--;
					end
				end
			end
			default: ;
		endcase
		res.total = ring_count;
	endtask

	always @(posedge clk) begin : check_results
		deque_result_t predicted;
		deque_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no request", removed_value, '0);
				end else begin
					want = pending_results.pop_front();
					if (removed_value !== want.removed)
						report_mismatch("removed_value", removed_value, want.removed);
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (entry_total !== want.total)
						report_mismatch("entry_total", 32'(entry_total), 32'(want.total));
				end
			end
			if (in_valid && in_ready) begin
				apply_deque_op(action, item_value, predicted);
				pending_results.push_back(req_typed ? req_expect : predicted);
			end
		end
	end

	always @(negedge clk) begin
		if (ready_phase == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern = 16'hFFFF;
				1: ready_pattern = 16'($urandom);
				2: ready_pattern = 16'($urandom & $urandom);
				default: ready_pattern = 16'h8000;
			endcase
		end
		out_ready <= ready_pattern[ready_phase];
		ready_phase = (ready_phase + 1) % 16;
	end

	task automatic add_row(input logic [2:0] act, input logic [31:0] val,
			input int unsigned reps, input bit typed, input logic [31:0] removed,
			input logic [1:0] st, input logic [4:0] total);
		stim_row_t row;
		row.act = act;
		row.val = val;
		row.reps = reps;
		row.typed = typed;
		row.exp.removed = removed;
		row.exp.status = st;
		row.exp.total = total;
		directed_rows.push_back(row);
	endtask

	// Called at a falling edge; returns right after the request is accepted.
	task automatic send_request(input logic [2:0] act, input logic [31:0] val,
			input bit typed, input deque_result_t exp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_typed = typed;
		req_expect = exp;
		in_valid <= 1'b1;
		action <= act;
		item_value <= val;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	initial begin
		int i;
		int r;
		int bias;
		int push_share;
		int pop_share;
		logic [2:0] act;
		logic [31:0] val;
		logic [3:0] pick;
		int push_lim [4] = '{60, 25, 40, 50};
		int pop_lim [4] = '{20, 50, 30, 10};

		add_row(ACT_POP_BACK, 32'h0000_0000, 1, 1, '0, ST_EMPTY, 5'd0);
		add_row(ACT_POP_FRONT, 32'h1234_5678, 1, 1, '0, ST_EMPTY, 5'd0);
		add_row(ACT_ERASE, 32'h0000_0000, 1, 1, '0, ST_EMPTY, 5'd0);
		add_row(ACT_SPARE_7, 32'hFFFF_FFFF, 1, 1, '0, ST_OK, 5'd0);
		add_row(ACT_PUSH_BACK, 32'h7FFF_FFFF, 1, 1, '0, ST_OK, 5'd1);
		add_row(ACT_PUSH_FRONT, 32'h8000_0000, 1, 1, '0, ST_OK, 5'd2);
		add_row(ACT_ERASE, 32'h0000_0005, 1, 1, '0, ST_NOT_FOUND, 5'd2);
		add_row(ACT_PUSH_BACK, 32'hFFFF_FFFF, 1, 0, '0, ST_OK, 5'd0);
		add_row(ACT_ERASE, 32'h7FFF_FFFF, 1, 0, '0, ST_OK, 5'd0);
		add_row(ACT_POP_BACK, 32'h0000_0000, 1, 0, '0, ST_OK, 5'd0);
		add_row(ACT_POP_FRONT, 32'h0000_0000, 1, 0, '0, ST_OK, 5'd0);
		add_row(ACT_PUSH_FRONT, 32'h0000_0100, 16, 0, '0, ST_OK, 5'd0);
		add_row(ACT_PUSH_BACK, 32'h0000_0000, 1, 1, '0, ST_FULL, 5'd16);
		add_row(ACT_PUSH_FRONT, 32'h0000_0001, 1, 1, '0, ST_FULL, 5'd16);
		add_row(ACT_ERASE, 32'h0000_0100, 1, 0, '0, ST_OK, 5'd0);
		add_row(ACT_ERASE, 32'h0000_010F, 1, 0, '0, ST_OK, 5'd0);
		add_row(ACT_ERASE, 32'h0000_0108, 1, 0, '0, ST_OK, 5'd0);
		add_row(ACT_POP_BACK, 32'h0000_0000, 1, 0, '0, ST_OK, 5'd0);
		add_row(ACT_POP_FRONT, 32'h0000_0000, 1, 0, '0, ST_OK, 5'd0);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[n]) begin
			for (r = 0; r < directed_rows[n].reps; r++)
				send_request(directed_rows[n].act, directed_rows[n].val + 32'(r),
					directed_rows[n].typed, directed_rows[n].exp);
		end

		bias = 0;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 48 == 0)
				bias = $urandom_range(0, 3);
			if (i % 200 == 199)
				drain_results();
			push_share = push_lim[bias];
			pop_share = pop_lim[bias];
			r = $urandom_range(0, 99);
			if (r < 3) begin
				case ($urandom_range(0, 2))
					0: act = ACT_SPARE_5;
					1: act = ACT_SPARE_6;
					default: act = ACT_SPARE_7;
				endcase
			end else if (r < 3 + push_share) begin
				act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
			end else if (r < 3 + push_share + pop_share) begin
				act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
			end else begin
				act = ACT_ERASE;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: val = 32'($urandom_range(0, 7)) - 32'd4;
				4: begin
					case ($urandom_range(0, 3))
						0: val = 32'h0000_0000;
						1: val = 32'hFFFF_FFFF;
						2: val = 32'h8000_0000;
						default: val = 32'h7FFF_FFFF;
					endcase
				end
				default: val = $urandom;
			endcase
			if (act == ACT_ERASE && ring_count != 0 && $urandom_range(0, 9) < 7) begin
				pick = ring_front + 4'($urandom_range(0, ring_count - 1));
				val = ring_store[pick];
			end
			send_request(act, val, 1'b0, '0);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("bounded_deque_with_erase: match");
		else
			$display("bounded_deque_with_erase: mismatch");
		$finish;
	end

endmodule
